[hw/rtl/i2cmbe_pkg.sv]
// Shared types, opcodes and line-level tables for the I2C master bit engine.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package i2cmbe_pkg;

   // Command opcodes carried in the op field
   typedef enum logic [2:0] {
      OP_RESET   = 3'd0,
      OP_START   = 3'd1,
      OP_STOP    = 3'd2,
      OP_RESTART = 3'd3,
      OP_WRITE   = 3'd4,
      OP_READ    = 3'd5,
      OP_ACK     = 3'd6,
      OP_NACK    = 3'd7
   } op_type;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned PHASE_W = 4;
   localparam int unsigned BIT_W   = 4;

   localparam logic [TICK_W-1:0]  HALF_BIT_RESET = 16'd4;
   localparam logic [PHASE_W-1:0] PHASE_IDLE     = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_LOW      = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_HIGH     = 4'd2;
   localparam logic [BIT_W-1:0]   WRITE_LAST     = 4'd9;
   localparam logic [BIT_W-1:0]   READ_LAST      = 4'd8;
   localparam logic [BIT_W-1:0]   ACK_SLOT       = 4'd8;

   // Number of phases of a fixed sequence command
   function automatic logic [PHASE_W-1:0] seq_len(input op_type op);
      logic [PHASE_W-1:0] len;
      case (op)
         OP_RESET:   len = 4'd2;
         OP_START:   len = 4'd2;
         OP_STOP:    len = 4'd3;
         OP_RESTART: len = 4'd4;
         OP_ACK:     len = 4'd4;
         OP_NACK:    len = 4'd3;
         default:    len = 4'd0;
      endcase
      return len;
   endfunction

   // Packed {scl, sda} level of a fixed sequence phase (index = phase - 1)
   function automatic logic [1:0] seq_level(input op_type op, input logic [1:0] idx);
      logic [1:0] lv;
      lv = 2'b11;
      case (op)
         OP_RESET: begin
            case (idx)
               2'd0:    lv = 2'b01;
               default: lv = 2'b11;
            endcase
         end
         OP_START: begin
            case (idx)
               2'd0:    lv = 2'b10;
               default: lv = 2'b00;
            endcase
         end
         OP_STOP: begin
            case (idx)
               2'd0:    lv = 2'b00;
               2'd1:    lv = 2'b10;
               default: lv = 2'b11;
            endcase
         end
         OP_RESTART: begin
            case (idx)
               2'd0:    lv = 2'b01;
               2'd1:    lv = 2'b11;
               2'd2:    lv = 2'b10;
               default: lv = 2'b00;
            endcase
         end
         OP_ACK: begin
            case (idx)
               2'd0:    lv = 2'b00;
               2'd1:    lv = 2'b10;
               2'd2:    lv = 2'b00;
               default: lv = 2'b01;
            endcase
         end
         OP_NACK: begin
            case (idx)
               2'd0:    lv = 2'b01;
               2'd1:    lv = 2'b11;
               default: lv = 2'b01;
            endcase
         end
         default: lv = 2'b11;
      endcase
      return lv;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/i2cmbe_if.sv]
// Valid/ready channel interfaces for the I2C master bit engine: tick words in,
// line/status words out, and the delay register write channel. Uses i2cmbe_pkg.
`default_nettype none

interface i2cmbe_req_if;
   logic                 valid;
   logic                 ready;
   logic                 cmd_valid;
   i2cmbe_pkg::op_type   op;
   logic [7:0]           wr_byte;
   logic                 sda_in;

   modport source (output valid, cmd_valid, op, wr_byte, sda_in, input ready);
   modport sink   (input valid, cmd_valid, op, wr_byte, sda_in, output ready);
endinterface

interface i2cmbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rd_byte;
   logic       ack_bit;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rd_byte, ack_bit,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rd_byte, ack_bit,
                   output ready);
endinterface

interface i2cmbe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [i2cmbe_pkg::TICK_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/i2c_master_bit_engine_top.sv]
// Top level of the I2C master bit engine: line sequencer with output register.
// Depends on i2cmbe_pkg and the channel interfaces in i2cmbe_if.sv.
`default_nettype none

// Each request word is one tick of the line sequencer and yields exactly one
// response word in the cycle after it is taken; a word is taken in every cycle
// while the response register is empty or being drained, so the sustained rate
// is one tick per cycle. The next-state logic is a single pass through a small
// command decoder, the half-bit tick compare and the level tables. A command
// offered while busy is dropped; the response carries SCL/SDA levels, busy,
// done, the last read byte and the last write acknowledge. The delay register
// (reset 4, zero counts as one) is written through the csr channel, always ready.
module i2c_master_bit_engine_top (
   input  wire                  clock,
   input  wire                  reset,
   i2cmbe_req_if.sink           req_port,
   i2cmbe_rsp_if.source         rsp_port,
   i2cmbe_csr_if.sink           csr_port
);

   // Sequencer state
   logic [i2cmbe_pkg::TICK_W-1:0]  half_bit_ff;
   logic                           scl_ff, scl_in;
   logic                           sda_ff, sda_in;
   i2cmbe_pkg::op_type             op_ff, op_in;
   logic [i2cmbe_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [i2cmbe_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [7:0]                     shift_ff, shift_in;
   logic [i2cmbe_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic                           ack_ff, ack_in;
   logic [7:0]                     rd_hold_ff, rd_hold_in;
   logic                           done_in;

   // Response register
   logic                           rsp_valid_ff;
   logic                           rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff;
   logic [7:0]                     rsp_rd_ff;
   logic                           rsp_ack_ff;

   logic                           accept;
   logic                           drive_en;
   logic                           bit_op;
   logic [i2cmbe_pkg::TICK_W-1:0]  half_eff;
   logic [i2cmbe_pkg::BIT_W-1:0]   last_bit;
   logic [1:0]                     lv;

   // Take a word whenever the response slot is free or draining
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   assign half_eff = (half_bit_ff == '0) ? {{(i2cmbe_pkg::TICK_W-1){1'b0}}, 1'b1} : half_bit_ff;
   assign bit_op   = (op_ff == i2cmbe_pkg::OP_WRITE) || (op_ff == i2cmbe_pkg::OP_READ);
   assign last_bit = (op_ff == i2cmbe_pkg::OP_WRITE) ? i2cmbe_pkg::WRITE_LAST
                                                     : i2cmbe_pkg::READ_LAST;

   // Advance the sequencer by one tick
   always_comb begin
      op_in      = op_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      ack_in     = ack_ff;
      rd_hold_in = rd_hold_ff;
      done_in    = 1'b0;
      drive_en   = 1'b0;

      if (phase_ff == i2cmbe_pkg::PHASE_IDLE) begin
         // Launch a new command
         if (req_port.cmd_valid) begin
            op_in    = req_port.op;
            phase_in = i2cmbe_pkg::PHASE_LOW;
            bit_in   = '0;
            tick_in  = {{(i2cmbe_pkg::TICK_W-1){1'b0}}, 1'b1};
            if (req_port.op == i2cmbe_pkg::OP_WRITE) begin
               shift_in = req_port.wr_byte;
            end else if (req_port.op == i2cmbe_pkg::OP_READ) begin
               shift_in = '0;
            end
            drive_en = 1'b1;
         end
      end else if (tick_ff < half_eff) begin
         // Hold the current levels
         tick_in = tick_ff + {{(i2cmbe_pkg::TICK_W-1){1'b0}}, 1'b1};
      end else begin
         tick_in = {{(i2cmbe_pkg::TICK_W-1){1'b0}}, 1'b1};
         if (bit_op) begin
            if (phase_ff == i2cmbe_pkg::PHASE_LOW) begin
               if (bit_ff >= last_bit) begin
                  done_in = 1'b1;
               end else begin
                  phase_in = i2cmbe_pkg::PHASE_HIGH;
                  drive_en = 1'b1;
               end
            end else begin
               // Sample SDA at the end of the high phase
               if (op_ff == i2cmbe_pkg::OP_READ) begin
                  shift_in = {shift_ff[6:0], req_port.sda_in};
               end else if (bit_ff == i2cmbe_pkg::ACK_SLOT) begin
                  ack_in = req_port.sda_in;
               end
               bit_in   = bit_ff + {{(i2cmbe_pkg::BIT_W-1){1'b0}}, 1'b1};
               phase_in = i2cmbe_pkg::PHASE_LOW;
               drive_en = 1'b1;
            end
         end else if (phase_ff < i2cmbe_pkg::seq_len(op_ff)) begin
            phase_in = phase_ff + {{(i2cmbe_pkg::PHASE_W-1){1'b0}}, 1'b1};
            drive_en = 1'b1;
         end else begin
            done_in = 1'b1;
         end
         // Finish the command
         if (done_in) begin
            if (op_ff == i2cmbe_pkg::OP_READ) begin
               rd_hold_in = shift_ff;
            end
            phase_in = i2cmbe_pkg::PHASE_IDLE;
            tick_in  = '0;
         end
      end
   end

   // Pick the line levels for the phase being entered
   always_comb begin
      scl_in = scl_ff;
      sda_in = sda_ff;
      lv     = i2cmbe_pkg::seq_level(op_in, phase_in[1:0] - 2'd1);
      if (drive_en) begin
         if ((op_in == i2cmbe_pkg::OP_WRITE) || (op_in == i2cmbe_pkg::OP_READ)) begin
            scl_in = (phase_in == i2cmbe_pkg::PHASE_HIGH);
            sda_in = 1'b1;
            if ((op_in == i2cmbe_pkg::OP_WRITE) && (bit_in < 4'd8)) begin
               sda_in = shift_in[3'd7 - bit_in[2:0]];
            end
         end else begin
            scl_in = lv[1];
            sda_in = lv[0];
         end
      end
   end

   // Hold state, delay register and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ff  <= i2cmbe_pkg::HALF_BIT_RESET;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         op_ff        <= i2cmbe_pkg::OP_RESET;
         phase_ff     <= i2cmbe_pkg::PHASE_IDLE;
         bit_ff       <= '0;
         shift_ff     <= '0;
         tick_ff      <= '0;
         ack_ff       <= 1'b0;
         rd_hold_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_port.valid) begin
            half_bit_ff <= csr_port.data;
         end
         if (accept) begin
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            op_ff      <= op_in;
            phase_ff   <= phase_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            tick_ff    <= tick_in;
            ack_ff     <= ack_in;
            rd_hold_ff <= rd_hold_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // Response payload needs no reset
      if (accept) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= (phase_in != i2cmbe_pkg::PHASE_IDLE);
         rsp_done_ff <= done_in;
         rsp_rd_ff   <= rd_hold_in;
         rsp_ack_ff  <= ack_in;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.scl_out  = rsp_scl_ff;
   assign rsp_port.sda_out  = rsp_sda_ff;
   assign rsp_port.busy_res = rsp_busy_ff;
   assign rsp_port.done_res = rsp_done_ff;
   assign rsp_port.rd_byte  = rsp_rd_ff;
   assign rsp_port.ack_bit  = rsp_ack_ff;

endmodule

`default_nettype wire

[verif/tb_i2c_master_bit_engine_top.sv]
// Self-checking bench for the I2C master bit engine: drives tick words with random
// pacing and checks every line/status word against a local line-sequencer model or a fixed word.
// Depends on i2cmbe_pkg, the channel interfaces and i2c_master_bit_engine_top.
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_top;

   localparam int RESET_CYCLES    = 11;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_TICKS     = 40;
   localparam int DELAY_STEPS     = 4;
   localparam int FAST_ROW        = 3;

   // Model phase codes
   localparam logic [3:0] ST_IDLE = i2cmbe_pkg::PHASE_IDLE;
   localparam logic [3:0] ST_LOW  = i2cmbe_pkg::PHASE_LOW;
   localparam logic [3:0] ST_HIGH = i2cmbe_pkg::PHASE_HIGH;
   localparam logic [3:0] ACK_POS = i2cmbe_pkg::ACK_SLOT;

   // Fixed sequence lengths and {scl, sda} levels per phase, indexed by opcode
   localparam logic [3:0] SEQ_PHASES [8] = '{4'd2, 4'd2, 4'd3, 4'd4, 4'd0, 4'd0, 4'd4, 4'd3};
   localparam logic [1:0] SEQ_LINES [8][4] = '{
      '{2'b01, 2'b11, 2'b11, 2'b11},
      '{2'b10, 2'b00, 2'b00, 2'b00},
      '{2'b00, 2'b10, 2'b11, 2'b11},
      '{2'b01, 2'b11, 2'b10, 2'b00},
      '{2'b11, 2'b11, 2'b11, 2'b11},
      '{2'b11, 2'b11, 2'b11, 2'b11},
      '{2'b00, 2'b10, 2'b00, 2'b01},
      '{2'b01, 2'b11, 2'b01, 2'b01}
   };

   typedef struct packed {
      logic               cmd_valid;
      i2cmbe_pkg::op_type op;
      logic [7:0]         wr_byte;
      logic               sda_in;
   } tick_word_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rd;
      logic       ack;
   } line_word_type;

   // One directed command: the command word, then ticks until the engine goes idle
   typedef struct packed {
      logic               cmd_valid;
      i2cmbe_pkg::op_type op;
      logic [7:0]         wr_byte;
      logic [7:0]         sda_pat;
      logic               ack_in;
      logic               junk;
      logic               typed;
      line_word_type      expv;
   } cmd_row_type;

   localparam line_word_type NO_EXP   = '0;
   localparam line_word_type EXP_IDLE = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
                                          rd: 8'h00, ack: 1'b0};
   localparam line_word_type EXP_RST1 = '{scl: 1'b0, sda: 1'b1, busy: 1'b1, done: 1'b0,
                                          rd: 8'h00, ack: 1'b0};
   localparam line_word_type EXP_STA1 = '{scl: 1'b1, sda: 1'b0, busy: 1'b1, done: 1'b0,
                                          rd: 8'h00, ack: 1'b0};

   localparam int NUM_ROWS = 21;
   cmd_row_type cmd_rows [NUM_ROWS] = '{
      '{1'b0, i2cmbe_pkg::OP_RESET,   8'h00, 8'h00, 1'b0, 1'b0, 1'b1, EXP_IDLE},
      '{1'b1, i2cmbe_pkg::OP_RESET,   8'h00, 8'h00, 1'b0, 1'b0, 1'b1, EXP_RST1},
      '{1'b1, i2cmbe_pkg::OP_START,   8'h00, 8'h00, 1'b0, 1'b0, 1'b1, EXP_STA1},
      '{1'b1, i2cmbe_pkg::OP_READ,    8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, EXP_RST1},
      '{1'b1, i2cmbe_pkg::OP_ACK,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_WRITE,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_WRITE,   8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_WRITE,   8'hA5, 8'h00, 1'b0, 1'b1, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_READ,    8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_NACK,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_RESTART, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_WRITE,   8'h80, 8'h00, 1'b1, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_READ,    8'h00, 8'h01, 1'b0, 1'b1, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_ACK,     8'h00, 8'h00, 1'b0, 1'b1, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_READ,    8'h00, 8'h5A, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_NACK,    8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_STOP,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, NO_EXP},
      '{1'b0, i2cmbe_pkg::OP_WRITE,   8'h3C, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_START,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_WRITE,   8'h7F, 8'h00, 1'b0, 1'b1, 1'b0, NO_EXP},
      '{1'b1, i2cmbe_pkg::OP_STOP,    8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_EXP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cmbe_req_if req_bus ();
   i2cmbe_rsp_if rsp_bus ();
   i2cmbe_csr_if csr_bus ();

   i2c_master_bit_engine_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Model state
   logic [15:0]        half_bit = 16'd4;
   logic               scl_lv   = 1'b1;
   logic               sda_lv   = 1'b1;
   i2cmbe_pkg::op_type cur_op   = i2cmbe_pkg::OP_RESET;
   logic [3:0]         ph       = ST_IDLE;
   logic [3:0]         bit_cnt  = 4'd0;
   logic [7:0]         shreg    = 8'h00;
   logic [15:0]        hold_cnt = 16'd0;
   logic               ack_lv   = 1'b0;
   logic [7:0]         rd_last  = 8'h00;

   line_word_type line_words_due [$];
   int  err_cnt    = 0;
   int  sent_ticks = 0;
   int  tx_calm    = 0;
   int  cycle_cnt  = 0;
   bit  rsp_hold_req = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Set line levels from the current command and phase
   function automatic void drive_lines();
      logic       d;
      logic [1:0] lv;
      if (cur_op == i2cmbe_pkg::OP_WRITE || cur_op == i2cmbe_pkg::OP_READ) begin
         d = 1'b1;
         if (cur_op == i2cmbe_pkg::OP_WRITE && bit_cnt < 4'd8)
            d = shreg[3'd7 - bit_cnt[2:0]];
         scl_lv = (ph == ST_HIGH);
         sda_lv = d;
      end else begin
         lv     = SEQ_LINES[cur_op][ph[1:0] - 2'd1];
         scl_lv = lv[1];
         sda_lv = lv[0];
      end
   endfunction

   function automatic void finish_cmd();
      if (cur_op == i2cmbe_pkg::OP_READ)
         rd_last = shreg;
      ph       = ST_IDLE;
      hold_cnt = 16'd0;
   endfunction

   // Move to the next phase; return 1 when the command completes
   function automatic logic advance_phase(input logic sda_smp);
      logic [3:0] last;
      hold_cnt = 16'd1;
      if (cur_op == i2cmbe_pkg::OP_WRITE || cur_op == i2cmbe_pkg::OP_READ) begin
         last = (cur_op == i2cmbe_pkg::OP_WRITE) ? 4'd9 : 4'd8;
         if (ph == ST_LOW) begin
            if (bit_cnt >= last) begin
               finish_cmd();
               return 1'b1;
            end
            ph = ST_HIGH;
         end else begin
            if (cur_op == i2cmbe_pkg::OP_READ)
               shreg = {shreg[6:0], sda_smp};
            else if (bit_cnt == ACK_POS)
               ack_lv = sda_smp;
            bit_cnt = bit_cnt + 4'd1;
            ph      = ST_LOW;
         end
         drive_lines();
         return 1'b0;
      end
      if (ph < SEQ_PHASES[cur_op]) begin
         ph = ph + 4'd1;
         drive_lines();
         return 1'b0;
      end
      finish_cmd();
      return 1'b1;
   endfunction

   // Advance the line sequencer by one tick and return the word it emits
   function automatic line_word_type predict_tick(input tick_word_type w);
      line_word_type r;
      logic          fin;
      logic [15:0]   lim;
      fin = 1'b0;
      if (ph == ST_IDLE) begin
         if (w.cmd_valid) begin
            cur_op   = w.op;
            ph       = ST_LOW;
            bit_cnt  = 4'd0;
            hold_cnt = 16'd1;
            if (w.op == i2cmbe_pkg::OP_WRITE)
               shreg = w.wr_byte;
            else if (w.op == i2cmbe_pkg::OP_READ)
               shreg = 8'h00;
            drive_lines();
         end
      end else begin
         lim = (half_bit == 16'd0) ? 16'd1 : half_bit;
         if (hold_cnt < lim)
            hold_cnt = hold_cnt + 16'd1;
         else
            fin = advance_phase(w.sda_in);
      end
      r.scl  = scl_lv;
      r.sda  = sda_lv;
      r.busy = (ph != ST_IDLE);
      r.done = fin;
      r.rd   = rd_last;
      r.ack  = ack_lv;
      return r;
   endfunction

   // SDA level a well-behaved slave would present for the bit in flight
   function automatic logic sda_for(input logic [7:0] pat, input logic ack_in);
      if (bit_cnt < 4'd8)
         return pat[3'd7 - bit_cnt[2:0]];
      return ack_in;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic tick_word_type filler_word(input logic [7:0] pat, input logic ack_in,
                                                 input logic junk, input logic noisy);
      tick_word_type w;
      w.cmd_valid = junk ? ($urandom_range(0, 3) != 0) : 1'b0;
      w.op        = i2cmbe_pkg::op_type'($urandom_range(0, 7));
      w.wr_byte   = 8'($urandom_range(0, 255));
      w.sda_in    = (noisy && $urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1))
                                                         : sda_for(pat, ack_in);
      return w;
   endfunction

   function automatic void cmp_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         err_cnt++;
      end
   endfunction

   // Hold off the sender now and then, with calm stretches in between
   task automatic sender_pause();
      int n;
      n = 0;
      if (tx_calm > 0)
         tx_calm--;
      else if ($urandom_range(0, 199) == 0)
         tx_calm = 150;
      else if ($urandom_range(0, 99) < 25)
         n = gap_len();
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Offer one tick word, wait for the handshake and queue its expected line word
   task automatic send_tick(input tick_word_type w, input logic typed,
                            input line_word_type tv);
      line_word_type pred;
      sender_pause();
      req_bus.valid     <= 1'b1;
      req_bus.cmd_valid <= w.cmd_valid;
      req_bus.op        <= w.op;
      req_bus.wr_byte   <= w.wr_byte;
      req_bus.sda_in    <= w.sda_in;
      do @(posedge clock); while (!req_bus.ready);
      pred = predict_tick(w);
      line_words_due.push_back(typed ? tv : pred);
      sent_ticks++;
      @(negedge clock);
   endtask

   // Feed ticks until the engine is idle again
   task automatic drain(input logic [7:0] pat, input logic ack_in, input logic junk,
                        input logic noisy);
      while (ph != ST_IDLE)
         send_tick(filler_word(pat, ack_in, junk, noisy), 1'b0, NO_EXP);
   endtask

   task automatic run_command(input i2cmbe_pkg::op_type op, input logic [7:0] wb);
      tick_word_type w;
      logic [7:0]    pat;
      logic          ack_in;
      logic          junk;
      pat       = 8'($urandom_range(0, 255));
      ack_in    = 1'($urandom_range(0, 1));
      junk      = ($urandom_range(0, 4) == 0);
      w.cmd_valid = 1'b1;
      w.op        = op;
      w.wr_byte   = wb;
      w.sda_in    = 1'($urandom_range(0, 1));
      send_tick(w, 1'b0, NO_EXP);
      drain(pat, ack_in, junk, 1'b1);
   endtask

   // One bus transaction: start, data bytes with acks, optional restart, stop or reset
   task automatic run_transfer();
      int n;
      run_command(i2cmbe_pkg::OP_START, 8'h00);
      n = $urandom_range(1, 3);
      repeat (n) begin
         if ($urandom_range(0, 1) != 0) begin
            run_command(i2cmbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)));
         end else begin
            run_command(i2cmbe_pkg::OP_READ, 8'($urandom_range(0, 255)));
            run_command(($urandom_range(0, 2) != 0) ? i2cmbe_pkg::OP_ACK
                                                    : i2cmbe_pkg::OP_NACK, 8'h00);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         run_command(i2cmbe_pkg::OP_RESTART, 8'h00);
         run_command(i2cmbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)));
      end
      run_command(($urandom_range(0, 9) == 0) ? i2cmbe_pkg::OP_RESET
                                              : i2cmbe_pkg::OP_STOP, 8'h00);
   endtask

   // Write the delay register once all line words have arrived
   task automatic write_delay(input logic [15:0] v);
      req_bus.valid <= 1'b0;
      while (line_words_due.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      half_bit = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Compare each line word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      line_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (line_words_due.size() == 0) begin
            $error("line word with no expectation pending");
            err_cnt++;
         end else begin
            want = line_words_due.pop_front();
            cmp_field("scl_out",  8'(want.scl),  8'(rsp_bus.scl_out));
            cmp_field("sda_out",  8'(want.sda),  8'(rsp_bus.sda_out));
            cmp_field("busy_res", 8'(want.busy), 8'(rsp_bus.busy_res));
            cmp_field("done_res", 8'(want.done), 8'(rsp_bus.done_res));
            cmp_field("rd_byte",  want.rd,       rsp_bus.rd_byte);
            cmp_field("ack_bit",  8'(want.ack),  8'(rsp_bus.ack_bit));
         end
      end
   end

   // Pace the receiver; one long hold-off on request to back up the engine
   initial begin : rsp_pacer
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 199) == 0)
               calm_left = 150;
            else if ($urandom_range(0, 99) < 25)
               stall_left = gap_len();
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb_i2c_master_bit_engine_top: FAIL");
         $finish;
      end
   end

   initial begin : stim
      tick_word_type w;
      logic [15:0]   dly;
      int            budget;
      req_bus.valid     = 1'b0;
      req_bus.cmd_valid = 1'b0;
      req_bus.op        = i2cmbe_pkg::OP_RESET;
      req_bus.wr_byte   = 8'h00;
      req_bus.sda_in    = 1'b1;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed commands: the first ones at the reset delay, the rest at the shortest
      foreach (cmd_rows[i]) begin
         if (i == FAST_ROW)
            write_delay(16'd1);
         w.cmd_valid = cmd_rows[i].cmd_valid;
         w.op        = cmd_rows[i].op;
         w.wr_byte   = cmd_rows[i].wr_byte;
         w.sda_in    = sda_for(cmd_rows[i].sda_pat, cmd_rows[i].ack_in);
         send_tick(w, cmd_rows[i].typed, cmd_rows[i].expv);
         drain(cmd_rows[i].sda_pat, cmd_rows[i].ack_in, cmd_rows[i].junk, 1'b0);
      end

      // Longest delay, then cut it short in the middle of a write
      write_delay(16'hFFFF);
      w.cmd_valid = 1'b1;
      w.op        = i2cmbe_pkg::OP_WRITE;
      w.wr_byte   = 8'hC3;
      w.sda_in    = 1'b0;
      send_tick(w, 1'b0, NO_EXP);
      repeat (40) send_tick(filler_word(8'h00, 1'b0, 1'b1, 1'b0), 1'b0, NO_EXP);
      write_delay(16'd2);
      drain(8'h00, 1'b0, 1'b0, 1'b0);

      // Random transactions under several delays
      for (int k = 0; k < DELAY_STEPS; k++) begin
         case (k)
            0:       dly = 16'd0;
            1:       dly = 16'd1;
            2:       dly = 16'd2;
            default: dly = 16'($urandom_range(1, 3));
         endcase
         write_delay(dly);
         // Back up the engine while the sender keeps offering words
         if (k == 0)
            rsp_hold_req = 1'b1;
         budget = sent_ticks + PHASE_TICKS;
         while (sent_ticks < budget) begin
            if ($urandom_range(0, 99) < 15) begin
               w.cmd_valid = 1'($urandom_range(0, 1));
               w.op        = i2cmbe_pkg::op_type'($urandom_range(0, 7));
               w.wr_byte   = 8'($urandom_range(0, 255));
               w.sda_in    = 1'($urandom_range(0, 1));
               send_tick(w, 1'b0, NO_EXP);
               drain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b1);
            end else begin
               run_transfer();
            end
         end
      end

      // Let the last words come out
      req_bus.valid <= 1'b0;
      while (line_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("tb_i2c_master_bit_engine_top: PASS");
      else
         $display("tb_i2c_master_bit_engine_top: FAIL");
      $finish;
   end

endmodule
